// File: hdl/kec256_pkg.sv
// Package for the Keccak-256 hash engine: lane and state types, sequencer
// states, permutation tables and the single-round function.
// No dependencies.
package kec256_pkg;

  localparam int unsigned LANE_W      = 64;
  localparam int unsigned STATE_LANES = 25;
  localparam int unsigned MAX_ROUNDS  = 24;
  localparam int unsigned LANE_IDX_W  = 5;
  localparam int unsigned WORD_BYTES  = 8;
  localparam int unsigned NUM_DIGEST  = 4;

  localparam logic [7:0] PAD_FIRST = 8'h01;
  localparam logic [7:0] PAD_LAST  = 8'h80;

  typedef logic [LANE_W-1:0]            lane_t;
  typedef lane_t [STATE_LANES-1:0]      state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_PERM,
    ST_DONE
  } seq_state_t;

  // Compressed round constants: bit b of the code sets bit 2**b-1 of the constant.
  localparam logic [6:0] RC_BITS [MAX_ROUNDS] = '{
    7'd1, 7'd26, 7'd94, 7'd112, 7'd31, 7'd33, 7'd121, 7'd85, 7'd14, 7'd12, 7'd53, 7'd38,
    7'd63, 7'd79, 7'd93, 7'd83, 7'd82, 7'd72, 7'd22, 7'd102, 7'd121, 7'd88, 7'd33, 7'd116
  };

  localparam logic [4:0] PI_CHAIN [MAX_ROUNDS] = '{
    5'd1, 5'd6, 5'd9, 5'd22, 5'd14, 5'd20, 5'd2, 5'd12, 5'd13, 5'd19, 5'd23, 5'd15,
    5'd4, 5'd24, 5'd21, 5'd8, 5'd16, 5'd5, 5'd3, 5'd18, 5'd17, 5'd11, 5'd7, 5'd10
  };

  localparam logic [5:0] RHO_AMOUNT [MAX_ROUNDS] = '{
    6'd1, 6'd62, 6'd28, 6'd27, 6'd36, 6'd44, 6'd6, 6'd55, 6'd20, 6'd3, 6'd10, 6'd43,
    6'd25, 6'd39, 6'd41, 6'd45, 6'd15, 6'd21, 6'd8, 6'd18, 6'd2, 6'd61, 6'd56, 6'd14
  };

  function automatic lane_t rotl(input lane_t v, input logic [5:0] n);
    return (v << n) | (v >> (7'd64 - {1'b0, n}));
  endfunction

  function automatic lane_t round_const(input logic [4:0] r);
    lane_t k;
    k = '0;
    for (int b = 0; b < 7; b++) begin
      k[(1 << b) - 1] = RC_BITS[r][b];
    end
    return k;
  endfunction

  // One full Keccak-f[1600] round: theta, rho, pi, chi, iota.
  function automatic state_t keccak_round(input state_t s, input lane_t rc);
    lane_t  col [5];
    lane_t  d   [5];
    state_t t;
    state_t u;
    state_t v;
    for (int x = 0; x < 5; x++) begin
      col[x] = s[x] ^ s[x+5] ^ s[x+10] ^ s[x+15] ^ s[x+20];
    end
    for (int x = 0; x < 5; x++) begin
      d[x] = rotl(col[(x + 1) % 5], 6'd1) ^ col[(x + 4) % 5];
    end
    for (int i = 0; i < 25; i++) begin
      t[i] = s[i] ^ d[i % 5];
    end
    u[0] = t[0];
    for (int i = 1; i < 25; i++) begin
      u[i] = rotl(t[i], RHO_AMOUNT[i-1]);
    end
    v[0] = u[0];
    for (int k = 0; k < 23; k++) begin
      v[PI_CHAIN[k]] = u[PI_CHAIN[k+1]];
    end
    v[10] = u[1];
    for (int y = 0; y < 25; y += 5) begin
      for (int x = 0; x < 5; x++) begin
        t[y+x] = v[y+x] ^ (~v[y + (x + 1) % 5] & v[y + (x + 2) % 5]);
      end
    end
    t[0] = t[0] ^ rc;
    return t;
  endfunction

endpackage

// File: hdl/keccak256_hash_engine.sv
// Keccak-256 hash engine top level: word absorption, padding, an iterative
// round unit and the digest output register.
// Depends on kec256_pkg.

// The engine hashes a message delivered as 64-bit items of eight little-endian
// bytes, using the original Keccak-256 padding (0x01 after the data, 0x80 in
// the last rate byte). Every item except the last must carry eight bytes; the
// last item carries 0 to 8 bytes in in_byte_count. A plain item is simply
// absorbed; the item that fills the rate block also starts the permutation,
// which runs ROUND_COUNT rounds (24 by default), one round per cycle on a
// single shared round unit, during which no item is taken. The last item is
// absorbed, padded and permuted (a full last item that closes a block is
// permuted first and then a padding block is padded and permuted), and the
// digest is then handed to the output register, where it stays until it is
// taken; the next message may start meanwhile, and a second digest waits in
// the engine until the register is free.
module keccak256_hash_engine #(
  parameter int unsigned ROUND_COUNT  = 24,
  parameter int unsigned RATE_LANES   = 17,
  parameter int unsigned DIGEST_LANES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_lane0,
  output logic [63:0] out_digest_lane1,
  output logic [63:0] out_digest_lane2,
  output logic [63:0] out_digest_lane3
);

  localparam int unsigned POS_W = (RATE_LANES > 1) ? $clog2(RATE_LANES) : 1;
  localparam int unsigned RND_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  kec256_pkg::seq_state_t state_r, state_nxt;
  kec256_pkg::state_t     lanes_r, lanes_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [RND_W-1:0]       round_r, round_nxt;
  logic [2:0]             pad_cnt_r, pad_cnt_nxt;
  logic                   pad_pend_r, pad_pend_nxt;  // padding block still owed
  logic                   final_r, final_nxt;        // running the closing permutation
  logic                   out_valid_r, out_valid_nxt;
  kec256_pkg::lane_t      digest_r [kec256_pkg::NUM_DIGEST];
  logic                   digest_load;

  logic                   in_acc;
  logic                   word_full;
  logic                   block_close;
  logic                   round_last;
  kec256_pkg::lane_t      word_in;
  kec256_pkg::lane_t      keep_mask;
  kec256_pkg::lane_t      pad_lane;

  assign in_ready    = (state_r == kec256_pkg::ST_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign word_full   = !in_last || (in_byte_count >= 4'(kec256_pkg::WORD_BYTES));
  assign block_close = (pos_r == POS_W'(RATE_LANES - 1));
  assign round_last  = (round_r == RND_W'(ROUND_COUNT - 1));

  // Bytes past the count on a short last item are dropped.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      keep_mask[8*b +: 8] = (4'(b) < in_byte_count) ? 8'hFF : 8'h00;
    end
  end

  assign word_in  = word_full ? in_data_word : (in_data_word & keep_mask);
  assign pad_lane = kec256_pkg::lane_t'(kec256_pkg::PAD_FIRST) << {pad_cnt_r, 3'b000};

  // Sequencer: absorb in IDLE, pad, permute one round a cycle, then deliver.
  always_comb begin
    state_nxt     = state_r;
    lanes_nxt     = lanes_r;
    pos_nxt       = pos_r;
    round_nxt     = round_r;
    pad_cnt_nxt   = pad_cnt_r;
    pad_pend_nxt  = pad_pend_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r && !out_ready;
    digest_load   = 1'b0;
    unique case (state_r)
      kec256_pkg::ST_IDLE: begin
        if (in_acc) begin
          for (int i = 0; i < 25; i++) begin
            if (5'(i) == kec256_pkg::LANE_IDX_W'(pos_r)) begin
              lanes_nxt[i] = lanes_r[i] ^ word_in;
            end
          end
          if (word_full) begin
            pad_cnt_nxt = 3'd0;
            if (block_close) begin
              pos_nxt      = '0;
              round_nxt    = '0;
              pad_pend_nxt = in_last;
              state_nxt    = kec256_pkg::ST_PERM;
            end else begin
              pos_nxt = pos_r + POS_W'(1);
              if (in_last) begin
                state_nxt = kec256_pkg::ST_PAD;
              end
            end
          end else begin
            pad_cnt_nxt = in_byte_count[2:0];
            state_nxt   = kec256_pkg::ST_PAD;
          end
        end
      end
      kec256_pkg::ST_PAD: begin
        for (int i = 0; i < 25; i++) begin
          lanes_nxt[i] = lanes_r[i]
            ^ ((5'(i) == kec256_pkg::LANE_IDX_W'(pos_r)) ? pad_lane : '0)
            ^ ((i == RATE_LANES - 1) ? {kec256_pkg::PAD_LAST, 56'd0} : '0);
        end
        pad_pend_nxt = 1'b0;
        final_nxt    = 1'b1;
        round_nxt    = '0;
        state_nxt    = kec256_pkg::ST_PERM;
      end
      kec256_pkg::ST_PERM: begin
        lanes_nxt = kec256_pkg::keccak_round(lanes_r,
                      kec256_pkg::round_const(5'(round_r)));
        round_nxt = round_r + RND_W'(1);
        if (round_last) begin
          round_nxt = '0;
          if (final_r) begin
            state_nxt = kec256_pkg::ST_DONE;
          end else if (pad_pend_r) begin
            state_nxt = kec256_pkg::ST_PAD;
          end else begin
            state_nxt = kec256_pkg::ST_IDLE;
          end
        end
      end
      kec256_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          digest_load   = 1'b1;
          out_valid_nxt = 1'b1;
          lanes_nxt     = '0;
          pos_nxt       = '0;
          final_nxt     = 1'b0;
          pad_pend_nxt  = 1'b0;
          state_nxt     = kec256_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kec256_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kec256_pkg::ST_IDLE;
      lanes_r     <= '0;
      pos_r       <= '0;
      round_r     <= '0;
      pad_cnt_r   <= '0;
      pad_pend_r  <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lanes_r     <= lanes_nxt;
      pos_r       <= pos_nxt;
      round_r     <= round_nxt;
      pad_cnt_r   <= pad_cnt_nxt;
      pad_pend_r  <= pad_pend_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Digest lanes beyond DIGEST_LANES read as zero.
  always_ff @(posedge clk) begin
    if (digest_load) begin
      for (int j = 0; j < kec256_pkg::NUM_DIGEST; j++) begin
        digest_r[j] <= (j < DIGEST_LANES) ? lanes_r[j] : '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digest_lane0 = digest_r[0];
  assign out_digest_lane1 = digest_r[1];
  assign out_digest_lane2 = digest_r[2];
  assign out_digest_lane3 = digest_r[3];

  // The absorb position never leaves the rate part of the state.
  a_pos_in_rate: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(RATE_LANES - 1))
    else $error("absorb position beyond rate lanes");

  // A last item always leads to padding or a permutation, never back to idle.
  a_last_pads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> (state_r == kec256_pkg::ST_PAD || state_r == kec256_pkg::ST_PERM))
    else $error("last item did not start padding");

  // Leaving DONE hands over a digest and returns to a cleared sponge.
  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kec256_pkg::ST_DONE && state_nxt == kec256_pkg::ST_IDLE
      |=> out_valid_r && pos_r == '0 && !final_r)
    else $error("digest hand-over incomplete");

  // The round counter rests at zero whenever the round unit is idle.
  a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != kec256_pkg::ST_PERM |-> round_r == '0)
    else $error("round counter not cleared outside permutation");

endmodule
